@@ design/imu_uart_frame_parser_unit_macros.svh @@
// assertion macros shared by the parser checker
`ifndef IMU_UART_FRAME_PARSER_UNIT_MACROS_SVH
`define IMU_UART_FRAME_PARSER_UNIT_MACROS_SVH

// same-cycle implication, reset masked
`define IUFP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("parser check failed");

// next-cycle implication, reset masked
`define IUFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("parser check failed");

`endif

@@ design/iufp_pkg.sv @@
// shared constants, types and status codes of the frame parser
package iufp_pkg;

  localparam int FRAME_LEN = 11;
  localparam int SUM_LEN   = 10;
  localparam int IDX_W     = 4;

  typedef logic [7:0] byte_t;
  typedef byte_t [FRAME_LEN-1:0] frame_t;

  localparam byte_t SYNC_BYTE  = 8'h55;
  localparam byte_t KIND_FIRST = 8'h50;
  localparam byte_t KIND_LAST  = 8'h54;

  // result status codes
  localparam logic [2:0] ST_STORED   = 3'd0;
  localparam logic [2:0] ST_DROPPED  = 3'd1;
  localparam logic [2:0] ST_GOOD     = 3'd2;
  localparam logic [2:0] ST_UNKNOWN  = 3'd3;
  localparam logic [2:0] ST_RESYNCED = 3'd4;
  localparam logic [2:0] ST_CLEARED  = 3'd5;

  // control from the sequencer to the frame buffer
  typedef struct packed {
    logic             wr_en;
    logic             shift_en;
    logic [IDX_W-1:0] wr_idx;
    byte_t            wr_data;
    logic [IDX_W-1:0] rd_idx;
  } store_ctl_t;

endpackage

@@ design/iufp_store.sv @@
// eleven-byte frame buffer with indexed write, shift-down and one indexed read
module iufp_store (
  input  logic               clk,
  input  iufp_pkg::store_ctl_t ctl,
  output iufp_pkg::byte_t    rd_data,
  output iufp_pkg::frame_t   frame
);
  import iufp_pkg::*;

  frame_t mem_r;

  // shift drops the oldest byte, top entry keeps its stale value
  always_ff @(posedge clk) begin
    if (ctl.shift_en) begin
      for (int i = 0; i < FRAME_LEN - 1; i++) begin
        mem_r[i] <= mem_r[i+1];
      end
    end else if (ctl.wr_en) begin
      mem_r[ctl.wr_idx] <= ctl.wr_data;
    end
  end

  assign rd_data = mem_r[ctl.rd_idx];
  assign frame   = mem_r;

endmodule

@@ design/iufp_acc.sv @@
// shared 8-bit wrapping adder that accumulates the checksum one byte a cycle while en is high
module iufp_acc (
  input  logic            clk,
  input  logic            en,
  input  logic            first,
  input  iufp_pkg::byte_t data,
  output iufp_pkg::byte_t total
);
  import iufp_pkg::*;

  byte_t acc_r;

  // first byte restarts the running sum
  assign total = (first ? 8'h00 : acc_r) + data;

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= total;
    end
  end

endmodule

@@ design/imu_uart_frame_parser_unit.sv @@
// A byte that does not close a frame gives its result in the cycle after acceptance.
// The closing byte of a frame starts a checksum over ten bytes (one byte per cycle through the
// shared adder) and on a bad sum a search for sync by one-byte shifts.
// Throughput: one byte per cycle inside a frame while no result waits at the output.
// in_ready is low while a frame is checked or while a result waits at the output.
// Synchronous active-low reset empties the buffer and clears the sequencer and output valid.
module imu_uart_frame_parser_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic [2:0]         out_frame_kind,
  output logic [7:0]         out_type_code,
  output logic signed [15:0] out_word_a,
  output logic signed [15:0] out_word_b,
  output logic signed [15:0] out_word_c,
  output logic signed [15:0] out_word_d,
  output logic [3:0]         out_fill_level
);
  import iufp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SUM  = 3'b010,
    S_SCAN = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] held_r, held_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  store_ctl_t       ctl;
  byte_t            rd_data;
  frame_t           frame;
  logic             acc_en;
  byte_t            acc_total;
  logic             load_out;

  logic [2:0]         res_status, res_kind;
  logic [7:0]         res_type;
  logic signed [15:0] res_wa, res_wb, res_wc, res_wd;
  logic [3:0]         res_fill;

  logic               out_valid_r;
  logic [2:0]         out_status_r, out_kind_r;
  logic [7:0]         out_type_r;
  logic signed [15:0] out_wa_r, out_wb_r, out_wc_r, out_wd_r;
  logic [3:0]         out_fill_r;

  iufp_store u_store (
    .clk     (clk),
    .ctl     (ctl),
    .rd_data (rd_data),
    .frame   (frame)
  );

  iufp_acc u_acc (
    .clk   (clk),
    .en    (acc_en),
    .first (idx_r == '0),
    .data  (rd_data),
    .total (acc_total)
  );

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);

  // sequencer: store bytes, sum the closed frame, then on a bad sum scan for a later sync
  always_comb begin
    state_nxt  = state_r;
    held_nxt   = held_r;
    idx_nxt    = idx_r;
    ctl        = '0;
    ctl.rd_idx = idx_r;
    acc_en     = 1'b0;
    load_out   = 1'b0;
    res_status = ST_STORED;
    res_kind   = '0;
    res_type   = '0;
    res_wa     = '0;
    res_wb     = '0;
    res_wc     = '0;
    res_wd     = '0;
    res_fill   = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          if (held_r == '0 && in_rx_byte != SYNC_BYTE) begin
            load_out   = 1'b1;
            res_status = ST_DROPPED;
          end else begin
            ctl.wr_en   = 1'b1;
            ctl.wr_idx  = held_r;
            ctl.wr_data = in_rx_byte;
            if (held_r == IDX_W'(FRAME_LEN - 1)) begin
              state_nxt = S_SUM;
              idx_nxt   = '0;
              held_nxt  = IDX_W'(FRAME_LEN);
            end else begin
              held_nxt   = held_r + 1'b1;
              load_out   = 1'b1;
              res_status = ST_STORED;
              res_fill   = held_r + 1'b1;
            end
          end
        end
      end
      S_SUM: begin
        acc_en = 1'b1;
        if (idx_r == IDX_W'(SUM_LEN - 1)) begin
          if (acc_total == frame[FRAME_LEN-1]) begin
            load_out = 1'b1;
            res_type = frame[1];
            if (frame[1] >= KIND_FIRST && frame[1] <= KIND_LAST) begin
              res_status = ST_GOOD;
              res_kind   = 3'(frame[1] - KIND_FIRST);
            end else begin
              res_status = ST_UNKNOWN;
            end
            res_wa    = $signed({frame[3], frame[2]});
            res_wb    = $signed({frame[5], frame[4]});
            res_wc    = $signed({frame[7], frame[6]});
            res_wd    = $signed({frame[9], frame[8]});
            held_nxt  = '0;
            state_nxt = S_IDLE;
          end else begin
            // bad sum: drop the leading sync byte and start scanning
            ctl.shift_en = 1'b1;
            held_nxt     = held_r - 1'b1;
            state_nxt    = S_SCAN;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_SCAN: begin
        if (held_r == '0) begin
          load_out   = 1'b1;
          res_status = ST_CLEARED;
          state_nxt  = S_IDLE;
        end else if (frame[0] == SYNC_BYTE) begin
          load_out   = 1'b1;
          res_status = ST_RESYNCED;
          res_fill   = held_r;
          state_nxt  = S_IDLE;
        end else begin
          ctl.shift_en = 1'b1;
          held_nxt     = held_r - 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
      idx_r   <= idx_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= res_status;
      out_kind_r   <= res_kind;
      out_type_r   <= res_type;
      out_wa_r     <= res_wa;
      out_wb_r     <= res_wb;
      out_wc_r     <= res_wc;
      out_wd_r     <= res_wd;
      out_fill_r   <= res_fill;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_frame_kind = out_kind_r;
  assign out_type_code  = out_type_r;
  assign out_word_a     = out_wa_r;
  assign out_word_b     = out_wb_r;
  assign out_word_c     = out_wc_r;
  assign out_word_d     = out_wd_r;
  assign out_fill_level = out_fill_r;

endmodule

@@ design/iufp_checker.sv @@
// port-level checker for the frame parser and its bind to the top level
`include "imu_uart_frame_parser_unit_macros.svh"

module iufp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_status,
  input logic [2:0] out_frame_kind,
  input logic [3:0] out_fill_level
);
  import iufp_pkg::*;

  logic st_empties;
  logic st_holds;

  // status codes that leave the buffer empty or holding bytes
  assign st_empties = (out_status == ST_DROPPED) || (out_status == ST_GOOD) ||
                      (out_status == ST_UNKNOWN) || (out_status == ST_CLEARED);
  assign st_holds   = (out_status == ST_STORED) || (out_status == ST_RESYNCED);

  // a pending result is held until taken
  `IUFP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // an accepted byte either shows a result next or keeps the input closed
  `IUFP_ASSERT_NEXT(a_in_busy, in_valid && in_ready, out_valid || !in_ready)

  // outcomes that empty the buffer report zero fill
  `IUFP_ASSERT_NOW(a_fill_empty, out_valid && st_empties, out_fill_level == 4'd0)

  // a stored byte or a resync leaves between one and ten bytes held
  `IUFP_ASSERT_NOW(a_fill_stored, out_valid && st_holds, out_fill_level != 4'd0 && out_fill_level <= 4'd10)

  // frame kind only set for known frames
  `IUFP_ASSERT_NOW(a_kind_zero, out_valid && out_status != ST_GOOD, out_frame_kind == 3'd0)

endmodule

bind imu_uart_frame_parser_unit iufp_checker u_iufp_checker (.*);
